// ===== rtl/core/ymr_pkg.sv =====
// Shared types, codes and the CRC-16 byte step for the YMODEM receiver.
package ymr_pkg;

   // Protocol bytes
   localparam logic [7:0] SohByte = 8'h01;
   localparam logic [7:0] StxByte = 8'h02;
   localparam logic [7:0] EotByte = 8'h04;
   localparam logic [7:0] AckByte = 8'h06;
   localparam logic [7:0] NakByte = 8'h15;
   localparam logic [7:0] CByte   = 8'h43;

   localparam logic [15:0] CrcPoly = 16'h1021;

   localparam logic [3:0] EotWaitReset = 4'd5;

   // Packet layout: header, block number, complement, payload, CRC high, CRC low
   localparam logic [10:0] ShortPayload = 11'd128;
   localparam logic [10:0] LongPayload  = 11'd1024;

   localparam int QueueDepthDefault = 4;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_REPLY   = 2'd1,
      KIND_VERDICT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_BEGIN    = 2'd0,
      VERDICT_DATA     = 2'd1,
      VERDICT_END      = 2'd2,
      VERDICT_CRC_FAIL = 2'd3
   } verdict_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  reply_byte;
      logic [7:0]  payload_byte;
      logic [9:0]  payload_offset;
      verdict_type verdict;
      logic [7:0]  packet_number;
   } result_type;

   // One queue entry: the results caused by one input transaction
   typedef struct packed {
      logic       dual;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

   function automatic result_type make_reply(input logic [7:0] b);
      result_type r;
      r = '0;
      r.kind = KIND_REPLY;
      r.reply_byte = b;
      return r;
   endfunction

   function automatic result_type make_payload(input logic [7:0] b, input logic [9:0] off);
      result_type r;
      r = '0;
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      r.payload_offset = off;
      return r;
   endfunction

   function automatic result_type make_verdict(input verdict_type v, input logic [7:0] num);
      result_type r;
      r = '0;
      r.kind = KIND_VERDICT;
      r.verdict = v;
      r.packet_number = num;
      return r;
   endfunction

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/ymr_front.sv =====
// Front end: accept transactions, track packet and session state, build result entries.
module ymr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data,
   input  logic                 req_valid,
   input  logic                 queue_full,
   input  logic                 req_opcode,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_chunk_start,
   output ymr_pkg::push_type    push
);
   import ymr_pkg::*;

   logic        accept;

   logic [3:0]  eot_wait_ticks_ff, eot_wait_ticks_in;
   logic        in_packet_ff, in_packet_in;
   logic [10:0] byte_count_ff, byte_count_in;
   logic        long_packet_ff, long_packet_in;
   logic [7:0]  header_byte_ff, header_byte_in;
   logic [7:0]  block_number_ff, block_number_in;
   logic [15:0] crc_running_ff, crc_running_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic        connected_ff, connected_in;
   logic        eot_pending_ff, eot_pending_in;
   logic [3:0]  eot_ticks_ff, eot_ticks_in;

   logic [10:0] payload_end;
   logic [10:0] pos_next;
   logic [9:0]  off_full;
   logic [4:0]  tick_cnt;
   logic [15:0] crc_rx;
   logic [1:0]  n;
   result_type  r0, r1;

   assign accept      = req_valid && !queue_full;
   assign payload_end = 11'd3 + (long_packet_ff ? LongPayload : ShortPayload);
   assign pos_next    = byte_count_ff + 11'd1;
   assign off_full    = byte_count_ff[9:0] - 10'd3;
   assign tick_cnt    = {1'b0, eot_ticks_ff} + 5'd1;
   assign crc_rx      = {crc_high_ff, req_rx_byte};

   always_comb begin
      eot_wait_ticks_in = csr_write_enable ? csr_write_data : eot_wait_ticks_ff;
      in_packet_in      = in_packet_ff;
      byte_count_in     = byte_count_ff;
      long_packet_in    = long_packet_ff;
      header_byte_in    = header_byte_ff;
      block_number_in   = block_number_ff;
      crc_running_in    = crc_running_ff;
      crc_high_in       = crc_high_ff;
      connected_in      = connected_ff;
      eot_pending_in    = eot_pending_ff;
      eot_ticks_in      = eot_ticks_ff;
      n  = 2'd0;
      r0 = '0;
      r1 = '0;

      if (accept) begin
         if (req_opcode) begin
            // timer tick
            if (!connected_ff) begin
               r0 = make_reply(CByte);
               n  = 2'd1;
            end
            if (eot_pending_ff) begin
               if (tick_cnt >= {1'b0, eot_wait_ticks_ff}) begin
                  connected_in   = 1'b0;
                  eot_pending_in = 1'b0;
                  eot_ticks_in   = 4'd0;
               end else begin
                  eot_ticks_in = tick_cnt[3:0];
               end
            end
         end else if (!in_packet_ff) begin
            if (req_chunk_start) begin
               if (req_rx_byte == SohByte || req_rx_byte == StxByte) begin
                  in_packet_in   = 1'b1;
                  long_packet_in = (req_rx_byte == StxByte);
                  header_byte_in = req_rx_byte;
                  byte_count_in  = 11'd1;
                  crc_running_in = 16'h0000;
               end else if (req_rx_byte == EotByte) begin
                  if (!eot_pending_ff) begin
                     r0 = make_reply(NakByte);
                     n  = 2'd1;
                     eot_pending_in = 1'b1;
                  end else begin
                     r0 = make_reply(AckByte);
                     r1 = make_reply(CByte);
                     n  = 2'd2;
                  end
               end
            end
         end else begin
            byte_count_in = pos_next;
            priority if (byte_count_ff == 11'd1) begin
               block_number_in = req_rx_byte;
            end else if (byte_count_ff == 11'd2) begin
               // complement byte is not checked
            end else if (byte_count_ff < payload_end) begin
               r0 = make_payload(req_rx_byte, off_full);
               n  = 2'd1;
               crc_running_in = crc_step(crc_running_ff, req_rx_byte);
            end else if (byte_count_ff == payload_end) begin
               crc_high_in = req_rx_byte;
            end else begin
               in_packet_in  = 1'b0;
               byte_count_in = 11'd0;
               n = 2'd1;
               if (crc_rx != crc_running_ff) begin
                  r0 = make_verdict(VERDICT_CRC_FAIL, block_number_ff);
               end else if (header_byte_ff == SohByte && block_number_ff == 8'd0) begin
                  if (eot_pending_ff) begin
                     r0 = make_verdict(VERDICT_END, block_number_ff);
                     r1 = make_reply(AckByte);
                     n  = 2'd2;
                     connected_in   = 1'b0;
                     eot_pending_in = 1'b0;
                     eot_ticks_in   = 4'd0;
                  end else begin
                     r0 = make_verdict(VERDICT_BEGIN, block_number_ff);
                     connected_in = 1'b1;
                  end
               end else begin
                  r0 = make_verdict(VERDICT_DATA, block_number_ff);
               end
            end
         end
      end
   end

   assign push.valid    = (n != 2'd0);
   assign push.entry.dual = (n == 2'd2);
   assign push.entry.r0 = r0;
   assign push.entry.r1 = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eot_wait_ticks_ff <= EotWaitReset;
         in_packet_ff      <= 1'b0;
         byte_count_ff     <= 11'd0;
         long_packet_ff    <= 1'b0;
         header_byte_ff    <= 8'd0;
         block_number_ff   <= 8'd0;
         crc_running_ff    <= 16'd0;
         crc_high_ff       <= 8'd0;
         connected_ff      <= 1'b0;
         eot_pending_ff    <= 1'b0;
         eot_ticks_ff      <= 4'd0;
      end else begin
         eot_wait_ticks_ff <= eot_wait_ticks_in;
         in_packet_ff      <= in_packet_in;
         byte_count_ff     <= byte_count_in;
         long_packet_ff    <= long_packet_in;
         header_byte_ff    <= header_byte_in;
         block_number_ff   <= block_number_in;
         crc_running_ff    <= crc_running_in;
         crc_high_ff       <= crc_high_in;
         connected_ff      <= connected_in;
         eot_pending_ff    <= eot_pending_in;
         eot_ticks_ff      <= eot_ticks_in;
      end
   end

endmodule

// ===== rtl/core/ymr_queue.sv =====
// Small FIFO of result entries between the front and back ends.
module ymr_queue #(
   parameter int Depth = ymr_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ymr_pkg::push_type    push,
   input  logic                 pop,
   output ymr_pkg::entry_type   head,
   output ymr_pkg::qstat_type   stat
);
   import ymr_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push.valid ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == CntW'(Depth));

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/ymr_back.sv =====
// Back end: unpack queue entries into single results and hold them in the output register.
module ymr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ymr_pkg::entry_type   head,
   input  ymr_pkg::qstat_type   stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ymr_pkg::result_type  rsp_result,
   output logic                 rsp_last
);
   import ymr_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       phase_ff, phase_in;
   result_type result_ff, result_in;
   logic       last_ff, last_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      result_in    = result_ff;
      last_in      = last_ff;
      if (slot_free) begin
         if (stat.not_empty) begin
            rsp_valid_in = 1'b1;
            if (!phase_ff && head.dual) begin
               // first of two: keep the entry for the second
               result_in = head.r0;
               last_in   = 1'b0;
               phase_in  = 1'b1;
            end else begin
               result_in = phase_ff ? head.r1 : head.r0;
               last_in   = 1'b1;
               phase_in  = 1'b0;
               pop       = 1'b1;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;
   assign rsp_last   = last_ff;

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

// ===== rtl/core/ymodem_packet_receiver.sv =====
// YMODEM receiver top level: front end, entry queue and back end with assertions.
//
// YMODEM packet receiver with CRC-16/XMODEM checking. Feed it received bytes
// (req_opcode 0, with req_chunk_start marking the first byte of each transport
// chunk) and handshake timer ticks (req_opcode 1). An idle SOH or STX at a chunk
// start opens a 128- or 1024-byte packet; payload bytes come out one per result
// with their offset, and after the second CRC byte a verdict result reports begin,
// data, end or CRC failure with the block number. Reply results carry the bytes
// to transmit (ACK, NAK, 'C') for EOT handling and tick-driven connection polling.
// Each transaction yields zero, one or two results; rsp_last marks the final one.
// Timing: while req_stall is low the front end takes one transaction every cycle
// with a fixed 8-bit parallel CRC step, so one byte per cycle is sustained.
// Results pass from the queue through the back end's output register to rsp_*,
// at most one per cycle, so the two results of one transaction leave in turn.
// QueueDepth entries sit between the two ends; req_stall rises only when the
// queue is full, which happens only under output stalls or long two-result runs.
// There is no clearing pass after reset. csr_write_data sets the number of
// ticks to wait for a second EOT (reset value 5); write it only while idle.
module ymodem_packet_receiver #(
   parameter int QueueDepth = ymr_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   input  logic       req_chunk_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_reply_byte,
   output logic [7:0] rsp_payload_byte,
   output logic [9:0] rsp_payload_offset,
   output logic [1:0] rsp_packet_verdict,
   output logic [7:0] rsp_packet_number,
   output logic       rsp_last
);
   import ymr_pkg::*;

   push_type   q_push;
   qstat_type  q_stat;
   entry_type  q_head;
   logic       q_pop;
   result_type rsp_result;

   // Stall the input only when the entry queue has no room
   assign req_stall = q_stat.full;

   ymr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .queue_full       (q_stat.full),
      .req_opcode       (req_opcode),
      .req_rx_byte      (req_rx_byte),
      .req_chunk_start  (req_chunk_start),
      .push             (q_push)
   );

   ymr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .head  (q_head),
      .stat  (q_stat)
   );

   ymr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .stat       (q_stat),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last)
   );

   // Break the result out onto its field ports
   assign rsp_result_kind    = rsp_result.kind;
   assign rsp_reply_byte     = rsp_result.reply_byte;
   assign rsp_payload_byte   = rsp_result.payload_byte;
   assign rsp_payload_offset = rsp_result.payload_offset;
   assign rsp_packet_verdict = rsp_result.verdict;
   assign rsp_packet_number  = rsp_result.packet_number;

`ifndef SYNTHESIS
   // Reset leaves the queue and the output register empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!q_stat.not_empty && !rsp_valid))
      else $error("queue or output not empty after reset");

   // An entry pushed into the queue is still there on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |=> q_stat.not_empty)
      else $error("pushed entry lost from queue");

   // The front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push.valid)
      else $error("push into full queue");
`endif

endmodule
